// File: design/vvc_config_record_parser_unit_defines.svh
// Assertion macros for the VVC configuration record parser.
`ifndef VVC_CONFIG_RECORD_PARSER_UNIT_DEFINES_SVH
`define VVC_CONFIG_RECORD_PARSER_UNIT_DEFINES_SVH

// The consequent is checked in the same cycle as the antecedent.
`define VVC_CRP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vvc_crp assertion failed");

// The consequent is checked in the cycle after the antecedent.
`define VVC_CRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vvc_crp assertion failed");

`endif

// File: design/vvc_crp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VVC configuration record parser package
// Field codes, the result record type and small helper functions.
// ----------------------------------------------------------------------------
package vvc_crp_pkg;

  localparam logic [4:0] FC_LEN_SIZE    = 5'd0;
  localparam logic [4:0] FC_PTL_PRESENT = 5'd1;
  localparam logic [4:0] FC_OLS_IDX     = 5'd2;
  localparam logic [4:0] FC_NUM_SUBL    = 5'd3;
  localparam logic [4:0] FC_CONST_FR    = 5'd4;
  localparam logic [4:0] FC_CHROMA      = 5'd5;
  localparam logic [4:0] FC_BIT_DEPTH   = 5'd6;
  localparam logic [4:0] FC_NUM_GCI     = 5'd7;
  localparam logic [4:0] FC_PROFILE     = 5'd8;
  localparam logic [4:0] FC_TIER        = 5'd9;
  localparam logic [4:0] FC_LEVEL       = 5'd10;
  localparam logic [4:0] FC_FRAME_ONLY  = 5'd11;
  localparam logic [4:0] FC_MULTILAYER  = 5'd12;
  localparam logic [4:0] FC_GCI_UPPER   = 5'd13;
  localparam logic [4:0] FC_GCI_LOWER   = 5'd14;
  localparam logic [4:0] FC_SUBL_MASK   = 5'd15;
  localparam logic [4:0] FC_SUBL_LEVEL  = 5'd16;
  localparam logic [4:0] FC_NUM_SUBPROF = 5'd17;
  localparam logic [4:0] FC_SUBPROF     = 5'd18;
  localparam logic [4:0] FC_MAX_WIDTH   = 5'd19;
  localparam logic [4:0] FC_MAX_HEIGHT  = 5'd20;
  localparam logic [4:0] FC_AVG_RATE    = 5'd21;
  localparam logic [4:0] FC_NUM_ARRAYS  = 5'd22;
  localparam logic [4:0] FC_COMPLETE    = 5'd23;
  localparam logic [4:0] FC_NAL_TYPE    = 5'd24;
  localparam logic [4:0] FC_NAL_COUNT   = 5'd25;
  localparam logic [4:0] FC_NAL_LEN     = 5'd26;
  localparam logic [4:0] FC_NAL_BYTE    = 5'd27;
  localparam logic [4:0] FC_DONE        = 5'd28;
  localparam logic [4:0] FC_ERR         = 5'd29;

  localparam logic [4:0] NAL_OPI = 5'd12;
  localparam logic [4:0] NAL_DCI = 5'd13;
  localparam logic [2:0] SLOT_UNKNOWN = 3'd7;
  localparam int unsigned MaxResults = 4;

  typedef struct packed {
    logic [4:0]  field_code;
    logic [31:0] field_value;
    logic [7:0]  element_index;
    logic [2:0]  array_slot;
    logic [15:0] nal_index;
    logic [15:0] byte_offset;
  } res_t;

  function automatic res_t mk_res(input logic [4:0] code, input logic [31:0] val,
                                  input logic [7:0] elem, input logic [2:0] slot,
                                  input logic [15:0] nal, input logic [15:0] off);
    res_t r;
    r.field_code    = code;
    r.field_value   = val;
    r.element_index = elem;
    r.array_slot    = slot;
    r.nal_index     = nal;
    r.byte_offset   = off;
    return r;
  endfunction

  function automatic logic [2:0] slot_of(input logic [4:0] t);
    logic [2:0] s;
    case (t)
      5'd15:   s = 3'd0;
      5'd16:   s = 3'd1;
      5'd14:   s = 3'd2;
      5'd12:   s = 3'd3;
      5'd13:   s = 3'd4;
      5'd17:   s = 3'd5;
      5'd23:   s = 3'd6;
      default: s = SLOT_UNKNOWN;
    endcase
    return s;
  endfunction

  // Returns {found, index} of the highest set flag below limit.
  function automatic logic [3:0] next_flag(input logic [6:0] flags, input logic [7:0] limit);
    logic [3:0] k;
    k = 4'd0;
    for (int i = 0; i < 7; i++) begin
      if ((8'(i) < limit) && flags[i]) begin
        k = {1'b1, 3'(i)};
      end
    end
    return k;
  endfunction

endpackage

// File: design/vvc_crp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VVC configuration record parser channels
// Byte input channel and tagged field output channel.
// ----------------------------------------------------------------------------
interface vvc_crp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       record_start;
  modport source (output valid, output in_byte, output record_start, input ready);
  modport sink (input valid, input in_byte, input record_start, output ready);
endinterface

interface vvc_crp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_code;
  logic [31:0] field_value;
  logic [7:0]  element_index;
  logic [2:0]  array_slot;
  logic [15:0] nal_index;
  logic [15:0] byte_offset;
  logic        last_of_run;
  modport source (output valid, output field_code, output field_value,
                  output element_index, output array_slot, output nal_index,
                  output byte_offset, output last_of_run, input ready);
  modport sink (input valid, input field_code, input field_value,
                input element_index, input array_slot, input nal_index,
                input byte_offset, input last_of_run, output ready);
endinterface

// File: design/vvc_config_record_parser_unit.sv
// Output: the first field of a byte appears in the cycle after its transfer.
// Throughput: one byte per cycle while it yields at most one field and the
// output is ready; a byte that yields more than one field holds the input
// until the result buffer, which sends one field per transfer, sends its last.
// Reset: rst_ni clears the parser to wait for a record start and empties the
// result buffer.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VVC configuration record parser
// Walks the record one byte at a time and emits every field as a tagged value.
// ----------------------------------------------------------------------------
module vvc_config_record_parser_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  vvc_crp_in_if.sink    in_i,
  vvc_crp_out_if.source out_o
);
  import vvc_crp_pkg::*;

  typedef enum logic [4:0] {
    PH_WAIT, PH_HDR, PH_FRAME, PH_BITDEPTH, PH_NBCI, PH_PROFILE, PH_LEVEL,
    PH_GCIU, PH_GCIL, PH_SUBFLAGS, PH_SUBLEVEL, PH_NSUBPROF, PH_SUBPROF,
    PH_WIDTH, PH_HEIGHT, PH_RATE, PH_NARRAYS, PH_ARRHDR, PH_NUMNALUS,
    PH_NALLEN, PH_PAYLOAD, PH_DONE
  } phase_e;

  phase_e      ph_q, ph_d;
  logic [31:0] pw_q, pw_d, gw;
  logic [1:0]  wbc_q, wbc_d;
  logic [2:0]  slc_q, slc_d;
  logic [6:0]  spf_q, spf_d;
  logic [7:0]  lc_q, lc_d, ll_q, ll_d, al_q, al_d;
  logic [2:0]  slot_q, slot_d;
  logic [15:0] ncnt_q, ncnt_d, nctr_q, nctr_d, nbl_q, nbl_d;
  res_t        res_q [MaxResults];
  res_t        res_d [MaxResults];
  logic [2:0]  n_q, n_d, rd_q;
  logic [7:0]  b;
  logic [3:0]  k;
  logic [7:0]  mask;
  logic [2:0]  sh;
  logic        in_xfer, out_xfer, last;

  assign b        = in_i.in_byte;
  assign last     = (rd_q + 3'd1) == n_q;
  assign out_o.valid = rd_q != n_q;
  assign out_xfer = out_o.valid && out_o.ready;
  assign in_i.ready = !out_o.valid || (out_o.ready && last);
  assign in_xfer  = in_i.valid && in_i.ready;

  assign out_o.field_code    = res_q[rd_q[1:0]].field_code;
  assign out_o.field_value   = res_q[rd_q[1:0]].field_value;
  assign out_o.element_index = res_q[rd_q[1:0]].element_index;
  assign out_o.array_slot    = res_q[rd_q[1:0]].array_slot;
  assign out_o.nal_index     = res_q[rd_q[1:0]].nal_index;
  assign out_o.byte_offset   = res_q[rd_q[1:0]].byte_offset;
  assign out_o.last_of_run   = last;

  always_comb begin
    ph_d = ph_q; pw_d = pw_q; wbc_d = wbc_q; slc_d = slc_q; spf_d = spf_q;
    lc_d = lc_q; ll_d = ll_q; al_d = al_q; slot_d = slot_q;
    ncnt_d = ncnt_q; nctr_d = nctr_q; nbl_d = nbl_q;
    n_d = 3'd0;
    k = 4'd0;
    mask = 8'd0;
    sh = 3'd0;
    for (int i = 0; i < MaxResults; i++) begin
      res_d[i] = '0;
    end
    if (in_i.record_start) begin
      ph_d = PH_HDR; pw_d = '0; wbc_d = '0; slc_d = '0; spf_d = '0;
      lc_d = '0; ll_d = '0; al_d = '0; slot_d = '0;
      ncnt_d = '0; nctr_d = '0; nbl_d = '0;
    end
    gw = (wbc_d == 2'd0) ? {24'd0, b} : {pw_d[23:0], b};
    case (ph_d)
      PH_HDR: begin
        res_d[0] = mk_res(FC_LEN_SIZE, 32'(b[2:1]), '0, '0, '0, '0);
        res_d[1] = mk_res(FC_PTL_PRESENT, 32'(b[0]), '0, '0, '0, '0);
        n_d = 3'd2;
        ph_d = b[0] ? PH_FRAME : PH_NARRAYS;
      end
      PH_FRAME: begin
        pw_d = gw;
        if (wbc_d == 2'd1) begin
          wbc_d = 2'd0;
          slc_d = gw[6:4];
          res_d[0] = mk_res(FC_OLS_IDX, 32'(gw[15:7]), '0, '0, '0, '0);
          res_d[1] = mk_res(FC_NUM_SUBL, 32'(gw[6:4]), '0, '0, '0, '0);
          res_d[2] = mk_res(FC_CONST_FR, 32'(gw[3:2]), '0, '0, '0, '0);
          res_d[3] = mk_res(FC_CHROMA, 32'(gw[1:0]), '0, '0, '0, '0);
          n_d = 3'd4;
          ph_d = PH_BITDEPTH;
        end else begin
          wbc_d = wbc_d + 2'd1;
        end
      end
      PH_BITDEPTH: begin
        res_d[0] = mk_res(FC_BIT_DEPTH, 32'(b[7:5]), '0, '0, '0, '0);
        n_d = 3'd1;
        ph_d = PH_NBCI;
      end
      PH_NBCI: begin
        ll_d = {2'd0, b[5:0]};
        res_d[0] = mk_res(FC_NUM_GCI, 32'(b[5:0]), '0, '0, '0, '0);
        n_d = 3'd1;
        ph_d = PH_PROFILE;
      end
      PH_PROFILE: begin
        res_d[0] = mk_res(FC_PROFILE, 32'(b[7:1]), '0, '0, '0, '0);
        res_d[1] = mk_res(FC_TIER, 32'(b[0]), '0, '0, '0, '0);
        n_d = 3'd2;
        ph_d = PH_LEVEL;
      end
      PH_LEVEL: begin
        res_d[0] = mk_res(FC_LEVEL, 32'(b), '0, '0, '0, '0);
        n_d = 3'd1;
        ph_d = PH_GCIU;
      end
      PH_GCIU: begin
        res_d[0] = mk_res(FC_FRAME_ONLY, 32'(b[7]), '0, '0, '0, '0);
        res_d[1] = mk_res(FC_MULTILAYER, 32'(b[6]), '0, '0, '0, '0);
        res_d[2] = mk_res(FC_GCI_UPPER, 32'(b[5:0]), '0, '0, '0, '0);
        n_d = 3'd3;
        if (ll_d > 8'd1) begin
          lc_d = 8'd0;
          ph_d = PH_GCIL;
        end else if (slc_d >= 3'd2) begin
          ph_d = PH_SUBFLAGS;
        end else begin
          spf_d = '0;
          ph_d = PH_NSUBPROF;
        end
      end
      PH_GCIL: begin
        res_d[0] = mk_res(FC_GCI_LOWER, 32'(b), lc_d, '0, '0, '0);
        n_d = 3'd1;
        lc_d = lc_d + 8'd1;
        if (({1'b0, lc_d} + 9'd1) >= {1'b0, ll_d}) begin
          if (slc_d >= 3'd2) begin
            ph_d = PH_SUBFLAGS;
          end else begin
            spf_d = '0;
            ph_d = PH_NSUBPROF;
          end
        end
      end
      PH_SUBFLAGS: begin
        sh = 3'(4'd9 - {1'b0, slc_d});
        mask = (8'd1 << (slc_d - 3'd1)) - 8'd1;
        spf_d = 7'((b >> sh) & mask);
        res_d[0] = mk_res(FC_SUBL_MASK, 32'(spf_d), '0, '0, '0, '0);
        n_d = 3'd1;
        k = next_flag(spf_d, 8'(slc_d - 3'd1));
        if (k[3]) begin
          lc_d = 8'(k[2:0]);
          ph_d = PH_SUBLEVEL;
        end else begin
          ph_d = PH_NSUBPROF;
        end
      end
      PH_SUBLEVEL: begin
        res_d[0] = mk_res(FC_SUBL_LEVEL, 32'(b), lc_d, '0, '0, '0);
        n_d = 3'd1;
        k = next_flag(spf_d, lc_d);
        if (k[3]) begin
          lc_d = 8'(k[2:0]);
        end else begin
          ph_d = PH_NSUBPROF;
        end
      end
      PH_NSUBPROF: begin
        ll_d = b;
        res_d[0] = mk_res(FC_NUM_SUBPROF, 32'(b), '0, '0, '0, '0);
        n_d = 3'd1;
        lc_d = 8'd0;
        ph_d = (b != 8'd0) ? PH_SUBPROF : PH_WIDTH;
      end
      PH_SUBPROF: begin
        pw_d = gw;
        if (wbc_d == 2'd3) begin
          wbc_d = 2'd0;
          res_d[0] = mk_res(FC_SUBPROF, gw, lc_d, '0, '0, '0);
          n_d = 3'd1;
          lc_d = lc_d + 8'd1;
          if (lc_d >= ll_d) begin
            ph_d = PH_WIDTH;
          end
        end else begin
          wbc_d = wbc_d + 2'd1;
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_RATE: begin
        pw_d = gw;
        if (wbc_d == 2'd1) begin
          wbc_d = 2'd0;
          res_d[0] = mk_res((ph_d == PH_WIDTH) ? FC_MAX_WIDTH :
                            (ph_d == PH_HEIGHT) ? FC_MAX_HEIGHT : FC_AVG_RATE,
                            32'(gw[15:0]), '0, '0, '0, '0);
          n_d = 3'd1;
          ph_d = (ph_d == PH_WIDTH) ? PH_HEIGHT :
                 (ph_d == PH_HEIGHT) ? PH_RATE : PH_NARRAYS;
        end else begin
          wbc_d = wbc_d + 2'd1;
        end
      end
      PH_NARRAYS: begin
        al_d = b;
        res_d[0] = mk_res(FC_NUM_ARRAYS, 32'(b), '0, '0, '0, '0);
        n_d = 3'd1;
        if (b == 8'd0) begin
          res_d[1] = mk_res(FC_DONE, '0, '0, '0, '0, '0);
          n_d = 3'd2;
          ph_d = PH_DONE;
        end else begin
          ph_d = PH_ARRHDR;
        end
      end
      PH_ARRHDR: begin
        slot_d = slot_of(b[4:0]);
        res_d[0] = mk_res(FC_COMPLETE, 32'(b[7]), '0, slot_d, '0, '0);
        res_d[1] = mk_res(FC_NAL_TYPE, 32'(b[4:0]), '0, slot_d, '0, '0);
        n_d = 3'd2;
        if (slot_d == SLOT_UNKNOWN) begin
          res_d[2] = mk_res(FC_ERR, '0, '0, slot_d, '0, '0);
          n_d = 3'd3;
        end
        nctr_d = '0;
        if (b[4:0] == NAL_OPI || b[4:0] == NAL_DCI) begin
          ncnt_d = 16'd1;
          res_d[n_d[1:0]] = mk_res(FC_NAL_COUNT, 32'd1, '0, slot_d, '0, '0);
          n_d = n_d + 3'd1;
          ph_d = PH_NALLEN;
        end else begin
          ph_d = PH_NUMNALUS;
        end
      end
      PH_NUMNALUS: begin
        pw_d = gw;
        if (wbc_d == 2'd1) begin
          wbc_d = 2'd0;
          ncnt_d = gw[15:0];
          nctr_d = '0;
          res_d[0] = mk_res(FC_NAL_COUNT, 32'(gw[15:0]), '0, slot_d, '0, '0);
          n_d = 3'd1;
          if (gw[15:0] == 16'd0) begin
            al_d = al_d - 8'd1;
            if (al_d != 8'd0) begin
              ph_d = PH_ARRHDR;
            end else begin
              res_d[1] = mk_res(FC_DONE, '0, '0, '0, '0, '0);
              n_d = 3'd2;
              ph_d = PH_DONE;
            end
          end else begin
            ph_d = PH_NALLEN;
          end
        end else begin
          wbc_d = wbc_d + 2'd1;
        end
      end
      PH_NALLEN: begin
        pw_d = gw;
        if (wbc_d == 2'd1) begin
          wbc_d = 2'd0;
          nbl_d = gw[15:0];
          pw_d = {16'd0, gw[15:0]};
          res_d[0] = mk_res(FC_NAL_LEN, 32'(gw[15:0]), '0, slot_d, nctr_d, '0);
          n_d = 3'd1;
          if (gw[15:0] == 16'd0) begin
            nctr_d = nctr_d + 16'd1;
            if (nctr_d < ncnt_d) begin
              ph_d = PH_NALLEN;
            end else begin
              al_d = al_d - 8'd1;
              if (al_d != 8'd0) begin
                ph_d = PH_ARRHDR;
              end else begin
                res_d[1] = mk_res(FC_DONE, '0, '0, '0, '0, '0);
                n_d = 3'd2;
                ph_d = PH_DONE;
              end
            end
          end else begin
            ph_d = PH_PAYLOAD;
          end
        end else begin
          wbc_d = wbc_d + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        res_d[0] = mk_res(FC_NAL_BYTE, 32'(b), '0, slot_d, nctr_d, pw_d[15:0] - nbl_d);
        n_d = 3'd1;
        nbl_d = nbl_d - 16'd1;
        if (nbl_d == 16'd0) begin
          nctr_d = nctr_d + 16'd1;
          if (nctr_d < ncnt_d) begin
            ph_d = PH_NALLEN;
          end else begin
            al_d = al_d - 8'd1;
            if (al_d != 8'd0) begin
              ph_d = PH_ARRHDR;
            end else begin
              res_d[1] = mk_res(FC_DONE, '0, '0, '0, '0, '0);
              n_d = 3'd2;
              ph_d = PH_DONE;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_WAIT; pw_q <= '0; wbc_q <= '0; slc_q <= '0; spf_q <= '0;
      lc_q <= '0; ll_q <= '0; al_q <= '0; slot_q <= '0;
      ncnt_q <= '0; nctr_q <= '0; nbl_q <= '0;
      n_q <= '0; rd_q <= '0;
    end else if (in_xfer) begin
      ph_q <= ph_d; pw_q <= pw_d; wbc_q <= wbc_d; slc_q <= slc_d; spf_q <= spf_d;
      lc_q <= lc_d; ll_q <= ll_d; al_q <= al_d; slot_q <= slot_d;
      ncnt_q <= ncnt_d; nctr_q <= nctr_d; nbl_q <= nbl_d;
      n_q <= n_d; rd_q <= '0;
    end else if (out_xfer) begin
      rd_q <= rd_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

endmodule

// File: design/vvc_crp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VVC configuration record parser checker
// Port-level properties of the parser, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "vvc_config_record_parser_unit_defines.svh"

module vvc_crp_prop_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_last_i,
  input logic [4:0] out_code_i
);
  import vvc_crp_pkg::*;

  `VVC_CRP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `VVC_CRP_ASSERT_SAME(a_code_range, out_valid_i, out_code_i <= FC_ERR)
  `VVC_CRP_ASSERT_SAME(a_ready_drain, in_ready_i,
                       !out_valid_i || (out_ready_i && out_last_i))
  `VVC_CRP_ASSERT_NEXT(a_done_ends, out_valid_i && out_ready_i && out_code_i == FC_DONE,
                       !out_valid_i || out_code_i == FC_LEN_SIZE)

endmodule

bind vvc_config_record_parser_unit vvc_crp_prop_checker u_vvc_crp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_last_i (out_o.last_of_run),
  .out_code_i (out_o.field_code)
);
